[sv/weighted_index_sampler_macros.svh]
// ----------------------------------------------------------------------------
// weighted_index_sampler assertion macros
// shared forms for the concurrent checks of the sampler
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_INDEX_SAMPLER_MACROS_SVH
`define WEIGHTED_INDEX_SAMPLER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define WIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WIS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wis_pkg.sv]
// ----------------------------------------------------------------------------
// wis_pkg
// types and fixed codes of the weighted index sampler
// ----------------------------------------------------------------------------
package wis_pkg;

    // operation codes of the input transaction
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_MASK   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_MAX    = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_MASK,
        ST_MUL,
        ST_SAMPLE,
        ST_MAX,
        ST_DONE
    } t_state;

    // configuration port
    localparam int unsigned PADDR_BITS  = 3;
    localparam int unsigned PDATA_BITS  = 32;
    localparam logic        REG_ENTRIES = 1'b0;
    localparam int unsigned CFG_BITS    = 9;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd256;

    // result fields
    localparam int unsigned OUT_IDX_BITS = 8;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

endpackage

[sv/wis_mul.sv]
// ----------------------------------------------------------------------------
// wis_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module wis_mul #(
    parameter int unsigned A_BITS = 16,
    parameter int unsigned B_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [A_BITS-1:0]        i_a,
    input  logic [B_BITS-1:0]        i_b,
    output logic                     o_done,
    output logic [A_BITS+B_BITS-1:0] o_prod
);

    localparam int unsigned P_BITS = A_BITS + B_BITS;
    localparam int unsigned C_BITS = $clog2(A_BITS + 1);
    localparam logic [C_BITS-1:0] LAST = C_BITS'(A_BITS - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [C_BITS-1:0] r_cnt, n_cnt;
    logic [A_BITS-1:0] r_a, n_a;
    logic [P_BITS-1:0] r_b, n_b;
    logic [P_BITS-1:0] r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_b    = P_BITS'(i_b);
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_a[0]) begin
                n_acc = r_acc + r_b;
            end
            n_a   = r_a >> 1;
            n_b   = r_b << 1;
            n_cnt = r_cnt + C_BITS'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[sv/weighted_index_sampler.sv]
// ----------------------------------------------------------------------------
// weighted_index_sampler
// weight table with running total, inverse-cdf sampling and arg-max search
// ----------------------------------------------------------------------------
// usage
//   input channel i_in_valid / o_in_stall carries one operation per transaction:
//   load a weight, mask a range, sample with a uniform fraction, or select max.
//   output channel o_out_valid / i_out_stall returns one result per operation
//   (chosen index and status, status 1 when sample or max meets a zero total).
//   the entries_in_use register sits on the apb port at byte address 0.
// steps; with the output register free, the result shows and the next
//   transaction is taken on the cycle after the done cycle
//   load        read old weight, write new one, adjust total
//   mask        span clipped to the clamped entries_in_use, one entry read
//               and zeroed per cycle
//   sample      serial multiply, then a cdf walk that stops at the chosen entry
//   select max  one entry compared per cycle
//   empty sample / select max, out-of-range load or mask: straight to done
//   a register write holds o_in_stall high while the total is summed again
// reset: a clearing pass writes zero to all MAX_ENTRIES entries, one per
//   cycle, during which o_in_stall is high; register writes still complete
// stall: a result waits in the output register; the next operation is taken
//   meanwhile and holds its result until the output register frees up
// ----------------------------------------------------------------------------
`include "weighted_index_sampler_macros.svh"

module weighted_index_sampler #(
    parameter int unsigned MAX_ENTRIES   = 256,
    parameter int unsigned WEIGHT_BITS   = 16,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_op,
    input  logic [7:0]                      i_start_index,
    input  logic [8:0]                      i_span_length,
    input  logic [15:0]                     i_weight,
    input  logic [15:0]                     i_uniform_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_chosen_index,
    output logic                            o_status,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wis_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [wis_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [wis_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready
);

    import wis_pkg::*;

    // address, counter and total widths
    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned IW = (CW > 10) ? CW : 10;
    localparam int unsigned TW = WEIGHT_BITS + AW;
    localparam int unsigned PW = TW + FRACTION_BITS;
    localparam logic [IW-1:0] MAX_W = IW'(MAX_ENTRIES);

    // weight memory, one write and one registered read per cycle
    logic [WEIGHT_BITS-1:0] r_weights [MAX_ENTRIES];
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [WEIGHT_BITS-1:0] mem_wd;
    logic [AW-1:0]          mem_ra;

    // control state
    t_state                 r_state, n_state;
    logic [CFG_BITS-1:0]    r_cfg, n_cfg;
    logic                   r_pend, n_pend;
    logic [TW-1:0]          r_total, n_total;
    logic [IW-1:0]          r_addr, n_addr;
    logic                   r_rd_vld, n_rd_vld;
    logic                   r_out_valid, n_out_valid;

    // payload
    logic [IW-1:0]            r_end, n_end;
    logic [IW-1:0]            r_rd_idx, n_rd_idx;
    logic [IW-1:0]            r_start, n_start;
    logic [WEIGHT_BITS-1:0]   r_wgt, n_wgt;
    logic [FRACTION_BITS-1:0] r_frac, n_frac;
    logic [TW-1:0]            r_cum, n_cum;
    logic [WEIGHT_BITS-1:0]   r_best, n_best;
    logic [IW-1:0]            r_best_idx, n_best_idx;
    logic [IW-1:0]            r_res_idx, n_res_idx;
    logic                     r_res_st, n_res_st;
    logic [OUT_IDX_BITS-1:0]  r_out_idx, n_out_idx;
    logic                     r_out_st, n_out_st;

    // multiplier for fraction times total
    logic          mul_start;
    logic          mul_done;
    logic [PW-1:0] mul_prod;

    // decoded inputs
    logic                     in_accept;
    logic                     out_free;
    logic                     cfg_we;
    logic [31:0]              wgt_ext;
    logic [31:0]              frac_ext;
    logic [IW-1:0]            in_start;
    logic [IW-1:0]            in_span;
    logic [IW-1:0]            cfg_ext;
    logic [IW-1:0]            used;
    logic [IW-1:0]            span_end;
    logic [IW-1:0]            mask_end;
    logic                     walk_issue;
    logic                     walk_idle;
    logic [TW-1:0]            cum_next;
    logic                     cdf_hit;

    wis_mul #(
        .A_BITS (FRACTION_BITS),
        .B_BITS (TW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_frac),
        .i_b     (r_total),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // handshakes
    assign o_in_stall = (r_state != ST_IDLE) || r_pend;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_we     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_ENTRIES) ? PDATA_BITS'(r_cfg) : '0;

    // field widths follow the parameters
    assign wgt_ext  = {16'd0, i_weight};
    assign frac_ext = {16'd0, i_uniform_value};
    assign in_start = IW'(i_start_index);
    assign in_span  = IW'(i_span_length);

    // clamped number of entries in use
    assign cfg_ext = IW'(r_cfg);
    assign used    = (r_cfg == '0) ? IW'(1) : ((cfg_ext > MAX_W) ? MAX_W : cfg_ext);

    // mask range end, clipped to the entries in use
    assign span_end = in_start + in_span;
    assign mask_end = (span_end > used) ? used : span_end;

    // walk over r_addr .. r_end-1, data returns in the cycle after the read
    assign walk_issue = r_addr < r_end;
    assign walk_idle  = !walk_issue && !r_rd_vld;
    assign cum_next   = r_cum + TW'(r_rd_data);
    assign cdf_hit    = {cum_next, {FRACTION_BITS{1'b0}}} >= mul_prod;

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_pend      = r_pend;
        n_total     = r_total;
        n_addr      = r_addr;
        n_rd_vld    = 1'b0;
        n_out_valid = (r_out_valid && !i_out_stall) ? 1'b0 : r_out_valid;
        n_end       = r_end;
        n_rd_idx    = r_rd_idx;
        n_start     = r_start;
        n_wgt       = r_wgt;
        n_frac      = r_frac;
        n_cum       = r_cum;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_res_idx   = r_res_idx;
        n_res_st    = r_res_st;
        n_out_idx   = r_out_idx;
        n_out_st    = r_out_st;
        mem_we      = 1'b0;
        mem_wa      = r_addr[AW-1:0];
        mem_wd      = '0;
        mem_ra      = r_addr[AW-1:0];
        mul_start   = 1'b0;

        // walking states share the read issue
        if ((r_state == ST_SUM) || (r_state == ST_MASK) ||
            (r_state == ST_SAMPLE) || (r_state == ST_MAX)) begin
            if (walk_issue) begin
                n_addr   = r_addr + IW'(1);
                n_rd_vld = 1'b1;
                n_rd_idx = r_addr;
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                // zero every entry after reset
                mem_we  = 1'b1;
                n_addr  = r_addr + IW'(1);
                n_total = '0;
                if (r_addr == MAX_W - IW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (r_pend) begin
                    // entries_in_use changed: rebuild the total
                    n_pend  = 1'b0;
                    n_addr  = '0;
                    n_end   = used;
                    n_total = '0;
                    n_state = ST_SUM;
                end else if (in_accept) begin
                    n_start   = in_start;
                    n_wgt     = wgt_ext[WEIGHT_BITS-1:0];
                    n_frac    = frac_ext[FRACTION_BITS-1:0];
                    n_res_idx = '0;
                    n_res_st  = STATUS_OK;
                    n_state   = ST_DONE;
                    unique case (t_op'(i_op))
                        OP_LOAD: begin
                            if (in_start < MAX_W) begin
                                n_state = ST_LOAD_RD;
                            end
                        end
                        OP_MASK: begin
                            if ((in_start < used) && (in_span != '0)) begin
                                n_addr  = in_start;
                                n_end   = mask_end;
                                n_state = ST_MASK;
                            end
                        end
                        OP_SAMPLE: begin
                            if (r_total == '0) begin
                                n_res_st = STATUS_EMPTY;
                            end else begin
                                // address clear means the multiplier is not launched yet
                                n_cum   = '0;
                                n_addr  = '0;
                                n_state = ST_MUL;
                            end
                        end
                        OP_MAX: begin
                            if (r_total == '0) begin
                                n_res_st = STATUS_EMPTY;
                            end else begin
                                n_addr  = '0;
                                n_end   = used;
                                n_state = ST_MAX;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                if (r_rd_vld) begin
                    n_total = r_total + TW'(r_rd_data);
                end
                if (walk_idle) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD_RD: begin
                mem_ra  = r_start[AW-1:0];
                n_state = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                // old weight is on the read port, swap it for the new one
                mem_we = 1'b1;
                mem_wa = r_start[AW-1:0];
                mem_wd = r_wgt;
                if (r_start < used) begin
                    n_total = r_total - TW'(r_rd_data) + TW'(r_wgt);
                end
                n_state = ST_DONE;
            end
            ST_MASK: begin
                // writes trail the reads by one entry, never the same address
                if (r_rd_vld) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_rd_idx[AW-1:0];
                    n_total = r_total - TW'(r_rd_data);
                end
                if (walk_idle) begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL: begin
                mul_start = (r_cum == '0) && !mul_done && (r_addr != MAX_W);
                if (mul_done) begin
                    n_addr  = '0;
                    n_end   = used;
                    n_state = ST_SAMPLE;
                end else begin
                    // mark the multiplier as launched
                    n_addr = MAX_W;
                end
            end
            ST_SAMPLE: begin
                if (r_rd_vld) begin
                    n_cum = cum_next;
                end
                if (r_rd_vld && cdf_hit) begin
                    n_res_idx = r_rd_idx;
                    n_state   = ST_DONE;
                end else if (walk_idle) begin
                    n_res_idx = used - IW'(1);
                    n_state   = ST_DONE;
                end
            end
            ST_MAX: begin
                // strict compare keeps the lowest index on ties
                if (r_rd_vld && ((r_rd_idx == '0) || (r_rd_data > r_best))) begin
                    n_best     = r_rd_data;
                    n_best_idx = r_rd_idx;
                end
                if (walk_idle) begin
                    n_res_idx = r_best_idx;
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx[OUT_IDX_BITS-1:0];
                    n_out_st    = r_res_st;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // register write; the clearing pass leaves a zero total for any n
        if (cfg_we && (paddr[2] == REG_ENTRIES)) begin
            n_cfg = pwdata[CFG_BITS-1:0];
            if (r_state != ST_CLEAR) begin
                n_pend = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cfg       <= CFG_RESET;
            r_pend      <= 1'b0;
            r_total     <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_pend      <= n_pend;
            r_total     <= n_total;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_end      <= n_end;
        r_rd_idx   <= n_rd_idx;
        r_start    <= n_start;
        r_wgt      <= n_wgt;
        r_frac     <= n_frac;
        r_cum      <= n_cum;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res_idx  <= n_res_idx;
        r_res_st   <= n_res_st;
        r_out_idx  <= n_out_idx;
        r_out_st   <= n_out_st;
    end

    // weight memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_weights[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_weights[mem_ra];
    end

    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_out_idx;
    assign o_status       = r_out_st;

    // checks
    `WIS_ASSERT_IMP(a_no_result_in_clear, i_clk, i_rst_n,
        r_state == ST_CLEAR, !o_out_valid, "result presented during clearing pass")
    `WIS_ASSERT_IMP(a_empty_gives_zero, i_clk, i_rst_n,
        o_out_valid && (o_status == STATUS_EMPTY), o_chosen_index == '0,
        "empty status with nonzero index")
    `WIS_ASSERT_IMP(a_result_from_done, i_clk, i_rst_n,
        $rose(o_out_valid), $past(r_state) == ST_DONE,
        "result raised outside the done state")

endmodule

[dv/tb_weighted_index_sampler.sv]
// ----------------------------------------------------------------------------
// tb_weighted_index_sampler
// self-checking bench for the weighted index sampler: load, mask, sample and
// select-max transactions go through a bit-accurate predictor of the weight
// table, each returned index and status is checked in order, and the
// entries_in_use register is swept over its extremes on the apb port
// ----------------------------------------------------------------------------
module tb_weighted_index_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    import wis_pkg::*;

    // geometry of the default build
    localparam int unsigned MAX_ENTRIES   = 256;
    localparam int unsigned FRACTION_BITS = 16;

    // apb byte addresses: entries_in_use, and one slot with no register behind it
    localparam logic [PADDR_BITS-1:0] ADDR_ENTRIES  = PADDR_BITS'(REG_ENTRIES) << 2;
    localparam logic [PADDR_BITS-1:0] ADDR_UNMAPPED = PADDR_BITS'(4);

    // idle / stall rate in percent, run limit in cycles, drain wait at the end
    localparam int unsigned IDLE_PCT    = 21;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 300;

    typedef struct packed {
        logic [7:0] index;
        logic       status;
    } t_sample_outcome;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op            = '0;
    logic [7:0]  i_start_index   = '0;
    logic [8:0]  i_span_length   = '0;
    logic [15:0] i_weight        = '0;
    logic [15:0] i_uniform_value = '0;

    // output channel
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_chosen_index;
    logic        o_status;

    // configuration port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_BITS-1:0] paddr   = '0;
    logic [PDATA_BITS-1:0] pwdata  = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    // predictor state: weight table, running total, raw register value
    logic [15:0] weight_table [MAX_ENTRIES];
    logic [23:0] running_total;
    logic [8:0]  entries_reg;

    // outcomes still owed by the block, oldest first
    t_sample_outcome expected_outcomes [$];

    // bookkeeping
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned setting_count = 0;
    int unsigned empty_results = 0;
    int unsigned draw_results  = 0;
    bit          calm_stretch  = 1'b0;

    weighted_index_sampler u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_start_index   (i_start_index),
        .i_span_length   (i_span_length),
        .i_weight        (i_weight),
        .i_uniform_value (i_uniform_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chosen_index  (o_chosen_index),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit, covers the clearing pass and the slowest legal run many times over
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_weighted_index_sampler failed");
            $finish;
        end
    end

    // receiver back-pressure, switched off during the calm stretch
    always @(posedge i_clk) begin
        i_out_stall <= !calm_stretch && ($urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // register value clamped to 1..MAX_ENTRIES
    function automatic int unsigned active_entries();
        if (entries_reg == 0)
            return 1;
        if (entries_reg > MAX_ENTRIES)
            return MAX_ENTRIES;
        return entries_reg;
    endfunction

    // total over the entries in use, redone after every change
    function automatic void resum_table();
        logic [23:0] acc;
        int unsigned n;
        acc = '0;
        n   = active_entries();
        for (int i = 0; i < n; i++)
            acc += weight_table[i];
        running_total = acc;
    endfunction

    function automatic void reset_table();
        foreach (weight_table[i])
            weight_table[i] = '0;
        running_total = '0;
        entries_reg   = CFG_RESET;
    endfunction

    // applies one transaction to the predictor and returns what the block owes
    function automatic t_sample_outcome apply_operation(
        input t_op         op,
        input logic [7:0]  start,
        input logic [8:0]  span,
        input logic [15:0] w,
        input logic [15:0] u
    );
        t_sample_outcome outcome;
        int unsigned     n;
        int unsigned     clip;
        int unsigned     pick;
        bit              found;
        logic [39:0]     target;
        logic [23:0]     cum;
        outcome.index  = '0;
        outcome.status = STATUS_OK;
        n = active_entries();
        case (op)
            OP_LOAD: begin
                // every 8-bit index lies inside the table, loads past n are kept
                weight_table[start] = w;
                resum_table();
            end
            OP_MASK: begin
                // start past the end does nothing, long spans clip to n
                if (start < n) begin
                    clip = span;
                    if (clip > n - start)
                        clip = n - start;
                    for (int i = 0; i < clip; i++)
                        weight_table[start + i] = '0;
                    resum_table();
                end
            end
            default: begin
                if (running_total == 0) begin
                    outcome.status = STATUS_EMPTY;
                end else if (op == OP_SAMPLE) begin
                    // first i with cum(i) * 2^16 >= u * total, exact in 40 bits
                    target = {24'b0, u} * {16'b0, running_total};
                    cum    = '0;
                    pick   = n - 1;
                    found  = 1'b0;
                    for (int i = 0; i < n; i++) begin
                        cum += weight_table[i];
                        if (!found && ({cum, {FRACTION_BITS{1'b0}}} >= target)) begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                    outcome.index = pick[7:0];
                end else begin
                    // lowest index wins a tie
                    pick = 0;
                    for (int i = 1; i < n; i++)
                        if (weight_table[i] > weight_table[pick])
                            pick = i;
                    outcome.index = pick[7:0];
                end
            end
        endcase
        return outcome;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: one outcome per accepted output transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_sample_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got index %0d status %0d",
                         $time, o_chosen_index, o_status);
                error_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_chosen_index !== want.index) begin
                    $display("%0t: chosen_index mismatch, expected %0d, got %0d",
                             $time, want.index, o_chosen_index);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left just after a rising edge
    // ------------------------------------------------------------------------

    // one input transaction, with random idle cycles in front
    task automatic send_item(
        input t_op         op,
        input logic [7:0]  start,
        input logic [8:0]  span,
        input logic [15:0] w,
        input logic [15:0] u
    );
        t_sample_outcome outcome;
        while (!calm_stretch && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_start_index   <= start;
        i_span_length   <= span;
        i_weight        <= w;
        i_uniform_value <= u;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        // accepted at this edge
        outcome = apply_operation(op, start, span, w, u);
        if (outcome.status == STATUS_EMPTY)
            empty_results++;
        else if (op == OP_SAMPLE || op == OP_MAX)
            draw_results++;
        expected_outcomes.insert(expected_outcomes.size(), outcome);
        items_sent++;
    endtask

    // stop sending and wait for every owed result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // apb write, only while the block is idle
    task automatic cfg_write(input logic [PADDR_BITS-1:0] addr, input logic [8:0] value);
        drain_results();
        // leave the bus quiet between apb transfers
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only register index 0 exists, other slots are ignored
        if (addr == ADDR_ENTRIES) begin
            entries_reg = value;
            resum_table();
            setting_count++;
        end
    endtask

    // apb read of entries_in_use, compared with the predictor's copy
    task automatic check_entries_readback();
        logic [PDATA_BITS-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ENTRIES;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PDATA_BITS'(entries_reg)) begin
            $display("%0t: entries_in_use readback mismatch, expected %0d, got %0d",
                     $time, entries_reg, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // table is all zero after reset, so draws report an empty distribution
    task automatic test_empty_table();
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'h1234);
        send_item(OP_SAMPLE, 8'd17,  9'd3,   16'hFFFF, 16'h0000);
        send_item(OP_MAX,    8'd255, 9'd256, 16'h5A5A, 16'hFFFF);
        send_item(OP_MASK,   8'd0,   9'd256, 16'h0000, 16'h0000);
        send_item(OP_LOAD,   8'd0,   9'd0,   16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'hFFFF);
    endtask

    // field extremes and the corner cases of each operation
    task automatic test_directed_cases();
        // zero fraction picks entry 0 even though its weight is zero
        send_item(OP_LOAD,   8'd5,   9'd0,   16'd100,  16'h0000);
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'h0000);
        // tie for the maximum, lowest index wins
        send_item(OP_LOAD,   8'd255, 9'd0,   16'hFFFF, 16'h0000);
        send_item(OP_LOAD,   8'd7,   9'd0,   16'hFFFF, 16'h0000);
        send_item(OP_MAX,    8'd0,   9'd0,   16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'hFFFF);
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'h8000);
        // short table: load past n is stored but not counted
        cfg_write(ADDR_ENTRIES, 9'd8);
        send_item(OP_LOAD,   8'd200, 9'd0,   16'h8000, 16'h0000);
        send_item(OP_MAX,    8'd0,   9'd0,   16'h0000, 16'h0000);
        // mask starting past the end, zero length, and clipped at the end
        send_item(OP_MASK,   8'd8,   9'd5,   16'h0000, 16'h0000);
        send_item(OP_MASK,   8'd3,   9'd0,   16'h0000, 16'h0000);
        send_item(OP_MASK,   8'd6,   9'd256, 16'h0000, 16'h0000);
        send_item(OP_MAX,    8'd0,   9'd0,   16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'h8000);
        // everything masked in use, draws go empty again
        send_item(OP_MASK,   8'd0,   9'd256, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'h4000);
    endtask

    // register extremes, readback, and a write to an unmapped slot
    task automatic test_register_access();
        // zero clamps to one entry
        cfg_write(ADDR_ENTRIES, 9'd0);
        check_entries_readback();
        send_item(OP_LOAD,   8'd0,   9'd0,   16'd1,    16'h0000);
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'hFFFF);
        // above the table size saturates, entry 200 now counts
        cfg_write(ADDR_ENTRIES, 9'd511);
        check_entries_readback();
        send_item(OP_MAX,    8'd0,   9'd0,   16'h0000, 16'h0000);
        // unmapped slot leaves entries_in_use alone
        cfg_write(ADDR_UNMAPPED, 9'd3);
        check_entries_readback();
        send_item(OP_SAMPLE, 8'd0,   9'd0,   16'h0000, 16'hABCD);
        cfg_write(ADDR_ENTRIES, 9'd1);
        check_entries_readback();
        cfg_write(ADDR_ENTRIES, 9'd256);
        check_entries_readback();
        send_item(OP_MAX,    8'd0,   9'd0,   16'h0000, 16'h0000);
    endtask

    // weights biased toward the interesting magnitudes
    function automatic logic [15:0] pick_weight();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 16'h0000;
        if (roll < 15)
            return 16'hFFFF;
        if (roll < 50)
            return 16'($urandom_range(1, 15));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // one register setting, then a burst of mostly well-formed transactions
    task automatic run_traffic_phase(
        input logic [8:0]  setting,
        input int unsigned item_count,
        input bit          no_idle
    );
        int unsigned n;
        int unsigned roll;
        t_op         op;
        logic [7:0]  start;
        logic [8:0]  span;
        logic [15:0] u;
        cfg_write(ADDR_ENTRIES, setting);
        calm_stretch <= no_idle;
        n = active_entries();
        repeat (item_count) begin
            roll  = $urandom_range(99);
            // unused fields carry random noise
            start = 8'($urandom_range(0, 255));
            span  = 9'($urandom_range(0, 256));
            u     = 16'($urandom_range(0, 16'hFFFF));
            if (roll < 10) begin
                // noise: any operation with any fields
                op = t_op'($urandom_range(0, 3));
            end else if (roll < 48) begin
                op = OP_LOAD;
                if ($urandom_range(9) < 8)
                    start = 8'($urandom_range(0, n - 1));
            end else if (roll < 56) begin
                op = OP_MASK;
                if ($urandom_range(9) < 8)
                    start = 8'($urandom_range(0, n - 1));
                if ($urandom_range(9) < 8)
                    span = 9'($urandom_range(0, 4));
            end else if (roll < 84) begin
                op = OP_SAMPLE;
                roll = $urandom_range(19);
                if (roll == 0)
                    u = 16'h0000;
                else if (roll == 1)
                    u = 16'hFFFF;
            end else begin
                op = OP_MAX;
            end
            send_item(op, start, span, pick_weight(), u);
        end
        calm_stretch <= 1'b0;
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(9'd4,   60, 1'b0);
        run_traffic_phase(9'd1,   30, 1'b0);
        run_traffic_phase(9'd0,   20, 1'b0);
        // long stretch with neither idle nor stall
        run_traffic_phase(9'd16,  80, 1'b1);
        run_traffic_phase(9'd40,  80, 1'b0);
        run_traffic_phase(9'd256, 50, 1'b0);
        run_traffic_phase(9'd511, 30, 1'b0);
        run_traffic_phase(9'($urandom_range(2, 64)),    90, 1'b0);
        run_traffic_phase(9'($urandom_range(257, 510)), 20, 1'b0);
        run_traffic_phase(9'($urandom_range(65, 255)),  40, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_directed_cases();
        test_register_access();
        test_random_traffic();

        // let every owed result come back, then watch for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions over %0d register writes", items_sent,
                 setting_count);
        $display("draws with a result: %0d, draws on an empty table: %0d", draw_results,
                 empty_results);
        if (error_count == 0) begin
            $display("tb_weighted_index_sampler passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb_weighted_index_sampler failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/wis_pkg.sv
sv/wis_mul.sv
sv/weighted_index_sampler.sv
dv/tb_weighted_index_sampler.sv
